// File: hw/rtl/pese_pkg.sv
// shared constants and control types for the prefix expression evaluator
`timescale 1ns / 1ps

package pese_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int WORD_W          = 32;
    localparam int TOK_W           = 8;
    localparam int ST_W            = 3;
    localparam int DIV_CNT_W       = $clog2(WORD_W + 1);

    localparam logic [TOK_W-1:0] TOK_MUL  = 8'h2A;
    localparam logic [TOK_W-1:0] TOK_ADD  = 8'h2B;
    localparam logic [TOK_W-1:0] TOK_SUB  = 8'h2D;
    localparam logic [TOK_W-1:0] TOK_DIV  = 8'h2F;
    localparam logic [TOK_W-1:0] TOK_ZERO = 8'h30;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_DIV0     = 3'd1;
    localparam logic [ST_W-1:0] ST_UNDER    = 3'd2;
    localparam logic [ST_W-1:0] ST_LEFTOVER = 3'd3;
    localparam logic [ST_W-1:0] ST_OVER     = 3'd4;

    typedef struct packed {
        logic accept;
        logic push;
        logic set_under;
        logic set_over;
        logic rd_below;
        logic alu_commit;
        logic div_by_zero;
        logic div_start;
        logic div_step;
        logic div_commit;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic in_is_op;
        logic in_last;
        logic err_pending;
        logic short_stack;
        logic full;
        logic op_is_div;
        logic divisor_zero;
        logic div_done;
        logic last_item;
        logic out_free;
    } sts_t;

endpackage

// File: hw/rtl/pese_ctrl.sv
// controller state machine for the prefix expression evaluator
`timescale 1ns / 1ps

module pese_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  pese_pkg::sts_t sts,
    output pese_pkg::cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_OPER = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = sts.in_last ? S_EMIT : S_IDLE;
                    if (!sts.err_pending)
                    begin
                        if (sts.in_is_op)
                        begin
                            if (sts.short_stack)
                            begin
                                cmd.set_under = 1'b1;
                            end
                            else
                            begin
                                cmd.rd_below = 1'b1;
                                state_next   = S_OPER;
                            end
                        end
                        else if (sts.full)
                        begin
                            cmd.set_over = 1'b1;
                        end
                        else
                        begin
                            cmd.push = 1'b1;
                        end
                    end
                end
            end
            S_OPER:
            begin
                state_next = sts.last_item ? S_EMIT : S_IDLE;
                if (!sts.op_is_div)
                begin
                    cmd.alu_commit = 1'b1;
                end
                else if (sts.divisor_zero)
                begin
                    cmd.div_by_zero = 1'b1;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.div_commit = 1'b1;
                    state_next     = sts.last_item ? S_EMIT : S_IDLE;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hw/rtl/pese_dp.sv
// datapath: operand stack, alu, serial divider and result register
`timescale 1ns / 1ps

module pese_dp
#(
    parameter int STACK_DEPTH = pese_pkg::STACK_DEPTH_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [pese_pkg::TOK_W-1:0]         token,
    input  logic                               last,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [pese_pkg::WORD_W-1:0] value,
    output logic [pese_pkg::ST_W-1:0]          status,
    input  pese_pkg::cmd_t                     cmd,
    output pese_pkg::sts_t                     sts
);

    localparam int W     = pese_pkg::WORD_W;
    localparam int DW    = $clog2(STACK_DEPTH + 1);
    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int MEM_N = STACK_DEPTH - 1;
    localparam int CW    = pese_pkg::DIV_CNT_W;

    logic [W-1:0] mem [0:MEM_N-1];

    logic [DW-1:0]                depth_reg, depth_next;
    logic [pese_pkg::ST_W-1:0]    err_reg, err_next;
    logic [W-1:0]                 tos_reg, tos_next;
    logic [W-1:0]                 rd_reg;
    logic [pese_pkg::TOK_W-1:0]   op_reg;
    logic                         last_reg;
    logic [W-1:0]                 rem_reg, quo_reg, dvs_reg;
    logic                         neg_reg;
    logic [CW-1:0]                cnt_reg;
    logic                         out_valid_reg;
    logic [W-1:0]                 value_reg;
    logic [pese_pkg::ST_W-1:0]    status_reg;

    logic [DW-1:0] depth_m1, depth_m2;
    logic [W-1:0]  push_val, alu_res, div_q, a_abs, b_abs;
    logic [W:0]    trial, trial_sub;
    logic          trial_ge;
    logic          one_left;

    assign depth_m1 = depth_reg - DW'(1);
    assign depth_m2 = depth_reg - DW'(2);
    assign push_val = W'(token) - W'(pese_pkg::TOK_ZERO);
    assign one_left = (depth_reg == DW'(1));

    always_comb
    begin
        case (op_reg)
            pese_pkg::TOK_MUL: alu_res = tos_reg * rd_reg;
            pese_pkg::TOK_ADD: alu_res = tos_reg + rd_reg;
            default:           alu_res = tos_reg - rd_reg;
        endcase
    end

    // restoring divider on magnitudes, one quotient bit per cycle
    assign a_abs     = tos_reg[W-1] ? (~tos_reg + W'(1)) : tos_reg;
    assign b_abs     = rd_reg[W-1] ? (~rd_reg + W'(1)) : rd_reg;
    assign trial     = {rem_reg, quo_reg[W-1]};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign trial_ge  = (trial >= {1'b0, dvs_reg});
    assign div_q     = neg_reg ? (~quo_reg + W'(1)) : quo_reg;

    assign sts.in_is_op     = (token inside {pese_pkg::TOK_MUL, pese_pkg::TOK_DIV,
                                             pese_pkg::TOK_ADD, pese_pkg::TOK_SUB});
    assign sts.in_last      = last;
    assign sts.err_pending  = (err_reg != pese_pkg::ST_OK);
    assign sts.short_stack  = (depth_reg < DW'(2));
    assign sts.full         = (depth_reg == DW'(STACK_DEPTH));
    assign sts.op_is_div    = (op_reg == pese_pkg::TOK_DIV);
    assign sts.divisor_zero = (rd_reg == '0);
    assign sts.div_done     = (cnt_reg == CW'(W));
    assign sts.last_item    = last_reg;
    assign sts.out_free     = !out_valid_reg || out_ready;

    always_comb
    begin
        depth_next = depth_reg;
        err_next   = err_reg;
        tos_next   = tos_reg;
        if (cmd.push)
        begin
            depth_next = depth_reg + DW'(1);
            tos_next   = push_val;
        end
        if (cmd.alu_commit)
        begin
            depth_next = depth_m1;
            tos_next   = alu_res;
        end
        if (cmd.div_commit)
        begin
            depth_next = depth_m1;
            tos_next   = div_q;
        end
        if (cmd.div_by_zero)
        begin
            depth_next = depth_m2;
            err_next   = pese_pkg::ST_DIV0;
        end
        if (cmd.set_under)
        begin
            err_next = pese_pkg::ST_UNDER;
        end
        if (cmd.set_over)
        begin
            err_next = pese_pkg::ST_OVER;
        end
        if (cmd.emit)
        begin
            depth_next = '0;
            err_next   = pese_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= '0;
            err_reg       <= pese_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            depth_reg <= depth_next;
            err_reg   <= err_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // operand stack below the top entry, single port
    always_ff @(posedge clk)
    begin
        if (cmd.push && depth_reg != '0)
        begin
            mem[depth_m1[AW-1:0]] <= tos_reg;
        end
        else if (cmd.rd_below)
        begin
            rd_reg <= mem[depth_m2[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg <= tos_next;
        if (cmd.accept)
        begin
            last_reg <= last;
            op_reg   <= token;
        end
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= a_abs;
            dvs_reg <= b_abs;
            neg_reg <= tos_reg[W-1] ^ rd_reg[W-1];
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? trial_sub[W-1:0] : trial[W-1:0];
            quo_reg <= {quo_reg[W-2:0], trial_ge};
            cnt_reg <= cnt_reg + CW'(1);
        end
        if (cmd.emit)
        begin
            if (err_reg != pese_pkg::ST_OK)
            begin
                status_reg <= err_reg;
                value_reg  <= '0;
            end
            else if (one_left)
            begin
                status_reg <= pese_pkg::ST_OK;
                value_reg  <= tos_reg;
            end
            else
            begin
                status_reg <= pese_pkg::ST_LEFTOVER;
                value_reg  <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

endmodule

// File: hw/rtl/prefix_expression_stack_evaluator_unit.sv
// top level of the prefix expression evaluator
//
// input channel: in_valid/in_ready carry one token word (token, last) per
// handshake, characters from rightmost to leftmost; last marks the leftmost.
// output channel: out_valid/out_ready carry one result word (value, status)
// per expression, issued after the token marked last.
// per token: a push or an error-skipped token is handled as it is taken, an
// operator reads the entry below the top from the single-port stack memory
// and then does the alu write-back, and a division by a nonzero operand
// runs the bit-serial divider before its write-back. after the last token
// the result register is loaded together with out_valid.
// reset: the stack is empty, no error is pending, no result is held.
// stall: a finished result waits in the output register while the next
// expression's tokens are taken; once that expression's last token is in,
// the input stays closed until the register has been read.
`timescale 1ns / 1ps

module prefix_expression_stack_evaluator_unit
#(
    parameter int STACK_DEPTH = pese_pkg::STACK_DEPTH_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [pese_pkg::TOK_W-1:0]         token,
    input  logic                               last,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [pese_pkg::WORD_W-1:0] value,
    output logic [pese_pkg::ST_W-1:0]          status
);

    pese_pkg::cmd_t cmd;
    pese_pkg::sts_t sts;

    pese_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pese_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .token     (token),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value),
        .status    (status),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// File: hw/rtl/pese_chk.sv
// port-level checker for the prefix expression evaluator and its bind
`timescale 1ns / 1ps

module pese_chk
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic [pese_pkg::TOK_W-1:0]         token,
    input logic                               last,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [pese_pkg::WORD_W-1:0] value,
    input logic [pese_pkg::ST_W-1:0]          status
);

    // waiting token word holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(token) && $stable(last))
        else $error("token word changed while waiting");

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value) && $stable(status))
        else $error("result word changed while stalled");

    // an error result carries a zero value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != pese_pkg::ST_OK |-> value == '0)
        else $error("nonzero value with error status");

    // a new result is loaded only while no token is being taken
    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result loaded while input was open");

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid)
        else $error("result present after reset");

endmodule

bind prefix_expression_stack_evaluator_unit pese_chk u_pese_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .token     (token),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .status    (status)
);
